>>> rtl/dpwp_pkg.sv
// dpwp_pkg: shared types, widths, register codes and reset values for the
// depth pixel to world point block; no dependencies
package dpwp_pkg;

	localparam int PIX_W     = 12;
	localparam int RAW_W     = 16;
	localparam int SLOT_W    = 4;
	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int CENTER_W  = 28;
	localparam int RANGE_W   = 23;
	localparam int MAG_W     = 28;
	localparam int POSE_SLOTS = 12;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam int COORD_BITS_DEF = 12;
	localparam int MID_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF  = 8;

	localparam logic [REG_IDX_W-1:0] REG_DEPTH_UNIT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE   = 3'd6;

	localparam logic [WORD_W-1:0]   RST_DEPTH_UNIT  = 32'd4294967;
	localparam logic [WORD_W-1:0]   RST_INV_FOCAL_X = 32'd11184810;
	localparam logic [WORD_W-1:0]   RST_INV_FOCAL_Y = 32'd11184810;
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 28'd20971520;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 28'd15728640;
	localparam logic [RANGE_W-1:0]  RST_MAX_RANGE   = 23'd327680;
	localparam logic [RANGE_W-1:0]  RST_MIN_RANGE   = 23'd6554;

	typedef struct packed {
		logic [WORD_W-1:0]   depth_unit;
		logic [WORD_W-1:0]   inv_focal_x;
		logic [WORD_W-1:0]   inv_focal_y;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [RANGE_W-1:0]  max_range;
		logic [RANGE_W-1:0]  min_range;
	} cfg_t;

	typedef struct packed {
		logic                     is_pose;
		logic                     miss;
		logic [RANGE_W-1:0]       depth;
		logic                     neg_x;
		logic [MAG_W-1:0]         mag_x;
		logic                     neg_y;
		logic [MAG_W-1:0]         mag_y;
		logic [SLOT_W-1:0]        slot;
		logic signed [WORD_W-1:0] word;
	} mid_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] world_x;
		logic signed [WORD_W-1:0] world_y;
		logic signed [WORD_W-1:0] world_z;
		logic                     is_miss;
	} out_item_t;

	localparam int MID_W = $bits(mid_item_t);
	localparam int OUT_W = $bits(out_item_t);

endpackage

>>> rtl/dpwp_fifo.sv
// dpwp_fifo: small register queue with occupancy count
// used between front and back and on the result side; depends on dpwp_pkg
module dpwp_fifo #(
	parameter int WIDTH = dpwp_pkg::MID_W,
	parameter int DEPTH = dpwp_pkg::MID_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem[rd_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

>>> rtl/dpwp_front.sv
// dpwp_front: takes items, scales raw depth, classifies hit, miss or drop,
// and forms pixel offsets; depends on dpwp_pkg
module dpwp_front #(
	parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
	parameter int MID_DEPTH  = dpwp_pkg::MID_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dpwp_pkg::cfg_t                        cfg,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  opcode,
	input  logic [dpwp_pkg::PIX_W-1:0]            pixel_col,
	input  logic [dpwp_pkg::PIX_W-1:0]            pixel_row,
	input  logic [dpwp_pkg::RAW_W-1:0]            raw_depth,
	input  logic [dpwp_pkg::SLOT_W-1:0]           pose_slot,
	input  logic signed [dpwp_pkg::WORD_W-1:0]    pose_word,
	input  logic [$clog2(MID_DEPTH+1)-1:0]        mid_count,
	output logic                                  mid_push,
	output dpwp_pkg::mid_item_t                   mid_item
);

	import dpwp_pkg::*;

	localparam int CNT_W  = $clog2(MID_DEPTH + 1);
	localparam int D_W    = CENTER_W + 1;
	localparam int PROD_W = RAW_W + WORD_W;
	localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

	logic                     accept;
	logic [PIX_W-1:0]         col_m;
	logic [PIX_W-1:0]         row_m;
	logic signed [D_W-1:0]    dx_in;
	logic signed [D_W-1:0]    dy_in;
	logic [PROD_W-1:0]        prod_in;

	logic                     v_s1;
	logic                     pose_s1;
	logic                     raw_zero_s1;
	logic [WORD_W-1:0]        depth_s1;
	logic signed [D_W-1:0]    dx_s1;
	logic signed [D_W-1:0]    dy_s1;
	logic [SLOT_W-1:0]        slot_s1;
	logic signed [WORD_W-1:0] word_s1;

	logic                     miss;
	logic                     drop;
	logic [D_W-1:0]           dx_abs;
	logic [D_W-1:0]           dy_abs;

	assign full   = ({1'b0, mid_count} + (CNT_W+1)'(v_s1)) >= (CNT_W+1)'(MID_DEPTH);
	assign accept = push && !full;

	assign col_m   = pixel_col & COORD_MASK;
	assign row_m   = pixel_row & COORD_MASK;
	assign dx_in   = $signed({1'b0, col_m, {FRAC_W{1'b0}}}) - $signed({1'b0, cfg.center_x});
	assign dy_in   = $signed({1'b0, row_m, {FRAC_W{1'b0}}}) - $signed({1'b0, cfg.center_y});
	assign prod_in = PROD_W'(raw_depth) * PROD_W'(cfg.depth_unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pose_s1     <= opcode;
			raw_zero_s1 <= (raw_depth == '0);
			depth_s1    <= prod_in[PROD_W-1:FRAC_W];
			dx_s1       <= dx_in;
			dy_s1       <= dy_in;
			slot_s1     <= pose_slot;
			word_s1     <= pose_word;
		end
	end

	// zero or far reading is a miss at max range, too close is dropped
	assign miss   = raw_zero_s1 || (depth_s1 > WORD_W'(cfg.max_range));
	assign drop   = !miss && (depth_s1 < WORD_W'(cfg.min_range));
	assign dx_abs = dx_s1[D_W-1] ? D_W'(-dx_s1) : D_W'(dx_s1);
	assign dy_abs = dy_s1[D_W-1] ? D_W'(-dy_s1) : D_W'(dy_s1);

	assign mid_push = v_s1 && (pose_s1 || !drop);

	always_comb begin
		mid_item.is_pose = pose_s1;
		mid_item.miss    = miss;
		mid_item.depth   = miss ? cfg.max_range : depth_s1[RANGE_W-1:0];
		mid_item.neg_x   = dx_s1[D_W-1];
		mid_item.mag_x   = dx_abs[MAG_W-1:0];
		mid_item.neg_y   = dy_s1[D_W-1];
		mid_item.mag_y   = dy_abs[MAG_W-1:0];
		mid_item.slot    = slot_s1;
		mid_item.word    = word_s1;
	end

	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (mid_count < CNT_W'(MID_DEPTH)))
		else $error("front pushed into a full queue");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(push && !full))
		else $error("front stage holds an item that was never accepted");

endmodule

>>> rtl/dpwp_back.sv
// dpwp_back: back-projection through the intrinsics, pose store and
// rotation plus translation to a saturated world point; depends on dpwp_pkg
module dpwp_back #(
	parameter int OUT_DEPTH = dpwp_pkg::OUT_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dpwp_pkg::cfg_t                        cfg,
	input  logic                                  mid_empty,
	input  dpwp_pkg::mid_item_t                   mid_item,
	output logic                                  mid_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]        out_count,
	output logic                                  out_push,
	output dpwp_pkg::out_item_t                   out_item
);

	import dpwp_pkg::*;

	localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 3;
	localparam int RP_W    = MAG_W + WORD_W;
	localparam int DP_W    = MAG_W + RANGE_W;
	localparam int CM_W    = DP_W - FRAC_W;
	localparam int PR_W    = 2 * WORD_W - 2;
	localparam int ACC_W   = 2 * WORD_W;
	localparam int SH_W    = ACC_W - 28;
	localparam int TOT_W   = SH_W + 1;
	localparam logic [CM_W-1:0] LIM = CM_W'(64'h8000_0000);
	localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] S_MIN = 32'sh8000_0000;

	function automatic logic signed [WORD_W-1:0] sat_cam(input logic neg,
		input logic [CM_W-1:0] m);
		logic signed [WORD_W-1:0] r;
		if (neg) begin
			r = (m >= LIM) ? S_MIN : -$signed(m[WORD_W-1:0]);
		end else begin
			r = (m >= LIM - 1'b1) ? S_MAX : $signed(m[WORD_W-1:0]);
		end
		return r;
	endfunction

	logic                     credit;
	logic [RP_W-1:0]          rpx;
	logic [RP_W-1:0]          rpy;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     pose_s1, pose_s2, pose_s3;
	logic                     miss_s1, miss_s2, miss_s3, miss_s4, miss_s5;
	logic [RANGE_W-1:0]       depth_s1, depth_s2;
	logic                     negx_s1, negx_s2, negy_s1, negy_s2;
	logic [MAG_W-1:0]         ratx_s1, raty_s1;
	logic [CM_W-1:0]          magx_s2, magy_s2;
	logic [SLOT_W-1:0]        slot_s1, slot_s2, slot_s3;
	logic signed [WORD_W-1:0] word_s1, word_s2, word_s3;
	logic signed [WORD_W-1:0] cam_s3 [3];
	logic [DP_W-1:0]          dpx;
	logic [DP_W-1:0]          dpy;

	logic signed [WORD_W-1:0] pose_q [POSE_SLOTS];
	logic signed [ACC_W-1:0]  prod_full [3][3];
	logic signed [PR_W-1:0]   prod_s4 [3][3];
	logic signed [WORD_W-1:0] t_s4 [3];
	logic signed [ACC_W-1:0]  sum_s5 [3];
	logic signed [WORD_W-1:0] t_s5 [3];
	logic signed [WORD_W-1:0] world [3];

	// room in the result queue for everything already in flight
	assign credit = (SUM_W'(out_count) + SUM_W'(v_s1) + SUM_W'(v_s2) + SUM_W'(v_s3)
		+ SUM_W'(v_s4) + SUM_W'(v_s5)) < SUM_W'(OUT_DEPTH);
	assign mid_pop = !mid_empty && credit;

	assign rpx = RP_W'(mid_item.mag_x) * RP_W'(cfg.inv_focal_x);
	assign rpy = RP_W'(mid_item.mag_y) * RP_W'(cfg.inv_focal_y);
	assign dpx = DP_W'(ratx_s1) * DP_W'(depth_s1);
	assign dpy = DP_W'(raty_s1) * DP_W'(depth_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && !pose_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pose_s1  <= mid_item.is_pose;
		miss_s1  <= mid_item.miss;
		depth_s1 <= mid_item.depth;
		negx_s1  <= mid_item.neg_x;
		negy_s1  <= mid_item.neg_y;
		ratx_s1  <= rpx[RP_W-1:WORD_W];
		raty_s1  <= rpy[RP_W-1:WORD_W];
		slot_s1  <= mid_item.slot;
		word_s1  <= mid_item.word;

		pose_s2  <= pose_s1;
		miss_s2  <= miss_s1;
		depth_s2 <= depth_s1;
		negx_s2  <= negx_s1;
		negy_s2  <= negy_s1;
		magx_s2  <= dpx[DP_W-1:FRAC_W];
		magy_s2  <= dpy[DP_W-1:FRAC_W];
		slot_s2  <= slot_s1;
		word_s2  <= word_s1;

		pose_s3   <= pose_s2;
		miss_s3   <= miss_s2;
		cam_s3[0] <= sat_cam(negx_s2, magx_s2);
		cam_s3[1] <= sat_cam(negy_s2, magy_s2);
		cam_s3[2] <= $signed(WORD_W'(depth_s2));
		slot_s3   <= slot_s2;
		word_s3   <= word_s2;
	end

	// pose words take effect in item order at the rotation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < POSE_SLOTS; k++) begin
				pose_q[k] <= '0;
			end
		end else if (v_s3 && pose_s3 && (slot_s3 < SLOT_W'(POSE_SLOTS))) begin
			pose_q[slot_s3] <= word_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_full[i][j] = pose_q[i*3+j] * cam_s3[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		miss_s4 <= miss_s3;
		miss_s5 <= miss_s4;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s4[i][j] <= prod_full[i][j][ACC_W-1:2];
			end
			t_s4[i]   <= pose_q[9+i];
			sum_s5[i] <= {{2{prod_s4[i][0][PR_W-1]}}, prod_s4[i][0]}
				+ {{2{prod_s4[i][1][PR_W-1]}}, prod_s4[i][1]}
				+ {{2{prod_s4[i][2][PR_W-1]}}, prod_s4[i][2]};
			t_s5[i]   <= t_s4[i];
		end
	end

	always_comb begin
		logic [SH_W-1:0]  sh;
		logic [TOT_W-1:0] tot;
		for (int i = 0; i < 3; i++) begin
			sh  = sum_s5[i][ACC_W-1:28];
			tot = {sh[SH_W-1], sh} + {{(TOT_W-WORD_W){t_s5[i][WORD_W-1]}}, t_s5[i]};
			if ((&tot[TOT_W-1:WORD_W-1]) || !(|tot[TOT_W-1:WORD_W-1])) begin
				world[i] = $signed(tot[WORD_W-1:0]);
			end else begin
				world[i] = tot[TOT_W-1] ? S_MIN : S_MAX;
			end
		end
	end

	assign out_push = v_s5;

	always_comb begin
		out_item.world_x = world[0];
		out_item.world_y = world[1];
		out_item.world_z = world[2];
		out_item.is_miss = miss_s5;
	end

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_count < CNT_W'(OUT_DEPTH)))
		else $error("back pushed into a full result queue");

	a_pose_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && pose_s3) |=> !v_s4)
		else $error("pose load item reached the result stages");

endmodule

>>> rtl/depth_pixel_to_world_point.sv
// depth_pixel_to_world_point: one item per cycle sustained while full stays low; a pixel result
// reaches the result ports through 1 front stage, queue, 5 back stages and result queue;
// pose loads give no result and apply in item order
// reset clears both queues and all pipeline valids, sets the pose store to zero and the
// configuration registers to their defaults
// depends on dpwp_pkg, dpwp_fifo, dpwp_front, dpwp_back
module depth_pixel_to_world_point #(
	parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
	parameter int MID_DEPTH  = dpwp_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH  = dpwp_pkg::OUT_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dpwp_pkg::ADDR_W-1:0]        paddr,
	input  logic [dpwp_pkg::WORD_W-1:0]        pwdata,
	output logic [dpwp_pkg::WORD_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               push,
	output logic                               full,
	input  logic                               opcode,
	input  logic [dpwp_pkg::PIX_W-1:0]         pixel_col,
	input  logic [dpwp_pkg::PIX_W-1:0]         pixel_row,
	input  logic [dpwp_pkg::RAW_W-1:0]         raw_depth,
	input  logic [dpwp_pkg::SLOT_W-1:0]        pose_slot,
	input  logic signed [dpwp_pkg::WORD_W-1:0] pose_word,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [dpwp_pkg::WORD_W-1:0] world_x,
	output logic signed [dpwp_pkg::WORD_W-1:0] world_y,
	output logic signed [dpwp_pkg::WORD_W-1:0] world_z,
	output logic                               is_miss
);

	import dpwp_pkg::*;

	localparam int MID_CW = $clog2(MID_DEPTH + 1);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	cfg_t                   cfg_q;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic                   cfg_wr;

	logic                   mid_push;
	logic                   mid_pop;
	logic                   mid_empty;
	logic [MID_CW-1:0]      mid_count;
	mid_item_t              mid_in;
	mid_item_t              mid_head;

	logic                   out_push;
	logic [OUT_CW-1:0]      out_count;
	out_item_t              out_in;
	out_item_t              out_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_unit  <= RST_DEPTH_UNIT;
			cfg_q.inv_focal_x <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y <= RST_INV_FOCAL_Y;
			cfg_q.center_x    <= RST_CENTER_X;
			cfg_q.center_y    <= RST_CENTER_Y;
			cfg_q.max_range   <= RST_MAX_RANGE;
			cfg_q.min_range   <= RST_MIN_RANGE;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEPTH_UNIT:  cfg_q.depth_unit  <= pwdata;
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= pwdata;
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= pwdata;
				REG_CENTER_X:    cfg_q.center_x    <= pwdata[CENTER_W-1:0];
				REG_CENTER_Y:    cfg_q.center_y    <= pwdata[CENTER_W-1:0];
				REG_MAX_RANGE:   cfg_q.max_range   <= pwdata[RANGE_W-1:0];
				REG_MIN_RANGE:   cfg_q.min_range   <= pwdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEPTH_UNIT:  prdata = cfg_q.depth_unit;
			REG_INV_FOCAL_X: prdata = cfg_q.inv_focal_x;
			REG_INV_FOCAL_Y: prdata = cfg_q.inv_focal_y;
			REG_CENTER_X:    prdata = WORD_W'(cfg_q.center_x);
			REG_CENTER_Y:    prdata = WORD_W'(cfg_q.center_y);
			REG_MAX_RANGE:   prdata = WORD_W'(cfg_q.max_range);
			REG_MIN_RANGE:   prdata = WORD_W'(cfg_q.min_range);
			default:         prdata = '0;
		endcase
	end

	dpwp_front #(
		.COORD_BITS (COORD_BITS),
		.MID_DEPTH  (MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.raw_depth (raw_depth),
		.pose_slot (pose_slot),
		.pose_word (pose_word),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_item  (mid_in)
	);

	dpwp_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.pop    (mid_pop),
		.rdata  (mid_head),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	dpwp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_head),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_in)
	);

	dpwp_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_in),
		.pop    (pop && !empty),
		.rdata  (out_head),
		.empty  (empty),
		.count  (out_count)
	);

	assign world_x = out_head.world_x;
	assign world_y = out_head.world_y;
	assign world_z = out_head.world_z;
	assign is_miss = out_head.is_miss;

endmodule
